@@ rtl/core/ddd_pkg.sv @@
package ddd_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned CountW  = 22;
  localparam int unsigned StatusW = 2;
  localparam int unsigned QuotW   = 8;
  localparam int unsigned SumW    = 23;

  // Reciprocal of 100: floor(v * 5243 / 2^19) equals v / 100 for v below 43699
  localparam int unsigned RecipMul   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipProdW = YearW + 13;

  localparam logic [YearW-1:0] YearMax = YearW'(9999);

  localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_INVALID = 2'd1;
  localparam logic [StatusW-1:0] STATUS_ORDER   = 2'd2;

  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   end_day;
    logic [MonthW-1:0] end_month;
    logic [YearW-1:0]  end_year;
  } dates_t;

  typedef struct packed {
    logic [CountW-1:0]  day_count;
    logic [StatusW-1:0] status;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_y;
    logic div_p;
    logic mul;
    logic sum;
    logic load_out;
    logic sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

  // Divide a year-sized value by 100
  function automatic logic [QuotW-1:0] div100(input logic [YearW-1:0] v);
    logic [RecipProdW-1:0] prod;
    prod = RecipProdW'(v) * RecipProdW'(RecipMul);
    return prod[RecipShift +: QuotW];
  endfunction

  // Days in a month, February taking the leap flag
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/ddd_ctrl.sv @@
module ddd_ctrl
  import ddd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  dates_valid,
  output logic  dates_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV_Y = 6'b000010,
    ST_DIV_P = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   sel, sel_next;

  // Step each date through divide, multiply and sum, start date first
  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      ST_IDLE: begin
        if (dates_valid) begin
          state_next = ST_DIV_Y;
          sel_next   = 1'b0;
        end
      end
      ST_DIV_Y: state_next = ST_DIV_P;
      ST_DIV_P: state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM: begin
        if (sel) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV_Y;
          sel_next   = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  // Decode commands
  assign dates_ready  = (state == ST_IDLE);
  assign cmd.load_in  = (state == ST_IDLE) && dates_valid;
  assign cmd.div_y    = (state == ST_DIV_Y);
  assign cmd.div_p    = (state == ST_DIV_P);
  assign cmd.mul      = (state == ST_MUL);
  assign cmd.sum      = (state == ST_SUM);
  assign cmd.load_out = (state == ST_DONE) && stat.out_free;
  assign cmd.sel      = sel;

endmodule

@@ rtl/core/ddd_datapath.sv @@
module ddd_datapath
  import ddd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dates_t  dates,
  input  cmd_t    cmd,
  output stat_t   stat,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  dates_t            held;
  logic [QuotW-1:0]  qy;
  logic [QuotW-1:0]  qp;
  logic              leap;
  logic [SumW-1:0]   m365;
  logic              valid_a, valid_b;
  logic [CountW-1:0] serial_a, serial_b;

  logic [DayW-1:0]   cur_d;
  logic [MonthW-1:0] cur_m;
  logic [YearW-1:0]  cur_y;
  logic [YearW-1:0]  cur_p;
  logic [YearW-1:0]  r100;
  logic              leap_now;
  logic              ok_now;
  logic [SumW-1:0]   serial_sum;
  logic [CountW-1:0] diff;

  // Select the date being worked on
  always_comb begin
    cur_d = cmd.sel ? held.end_day   : held.start_day;
    cur_m = cmd.sel ? held.end_month : held.start_month;
    cur_y = cmd.sel ? held.end_year  : held.start_year;
  end

  assign cur_p = cur_y - YearW'(1);

  // Leap rule from the year and its quotient by 100
  assign r100     = cur_y - (YearW'(qy) * YearW'(100));
  assign leap_now = ((cur_y[1:0] == 2'b00) && (r100 != '0)) ||
                    ((r100 == '0) && (qy[1:0] == 2'b00));

  assign ok_now = (cur_m >= MonthW'(1)) && (cur_m <= MonthW'(12)) &&
                  (cur_y >= YearW'(1)) && (cur_y <= YearMax) &&
                  (cur_d >= DayW'(1)) && (cur_d <= month_len(cur_m, leap_now));

  // Serial day number from 0001-01-01
  assign serial_sum = m365
                    + SumW'(cur_p >> 2)
                    - SumW'(qp)
                    + SumW'(qp >> 2)
                    + SumW'(days_before(cur_m))
                    + SumW'((cur_m > MonthW'(2)) && leap)
                    + SumW'(cur_d)
                    - SumW'(1);

  assign diff = serial_b - serial_a;

  // Hold the dates and the intermediate values
  always_ff @(posedge clk) begin
    if (cmd.load_in) held <= dates;
    if (cmd.div_y) qy <= div100(cur_y);
    if (cmd.div_p) begin
      qp   <= div100(cur_p);
      leap <= leap_now;
      if (cmd.sel) valid_b <= ok_now;
      else         valid_a <= ok_now;
    end
    if (cmd.mul) m365 <= SumW'(cur_p) * SumW'(365);
    if (cmd.sum) begin
      if (cmd.sel) serial_b <= serial_sum[CountW-1:0];
      else         serial_a <= serial_sum[CountW-1:0];
    end
  end

  // Output register: load the finished item, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (!valid_a || !valid_b) begin
        result.day_count <= '0;
        result.status    <= STATUS_INVALID;
      end else if (serial_a > serial_b) begin
        result.day_count <= '0;
        result.status    <= STATUS_ORDER;
      end else begin
        result.day_count <= diff;
        result.status    <= STATUS_OK;
      end
    end
  end

  assign stat.out_free = !result_valid || result_ready;

endmodule

@@ rtl/core/date_difference_in_days_core.sv @@
// Channel | Handshake                   | Payload
// dates   | dates_valid / dates_ready   | dates  (start and end day, month, year)
// result  | result_valid / result_ready | result (day_count, status)
//
// A result is loaded after four steps per date (divide year, divide year-1 and
// check, multiply by 365, sum), each divide by 100 done as a reciprocal
// multiply, then a final step to compare and load. A new item can be taken
// the cycle after the result is loaded; none is taken while one is in work.
// Reset (rst, synchronous) empties the result register and idles the controller.
// A stalled result holds the controller in its final step until space frees.
module date_difference_in_days_core
  import ddd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    dates_valid,
  output logic    dates_ready,
  input  dates_t  dates,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  ddd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .dates_valid (dates_valid),
    .dates_ready (dates_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  ddd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dates        (dates),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The controller is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    dates_valid && dates_ready |=> !dates_ready)
    else $error("dates_ready high in the cycle after an item was accepted");

  // An error result carries a zero count
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STATUS_OK) |-> (result.day_count == '0))
    else $error("nonzero day_count on an error status");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == STATUS_OK) ||
                     (result.status == STATUS_INVALID) ||
                     (result.status == STATUS_ORDER))
    else $error("undefined status code");

  // A new result is loaded only while the controller is busy
  a_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !dates_ready)
    else $error("result loaded while idle");

endmodule
